>>> design/billboard_quad_expand_core_defines.svh
// ----------------------------------------------------------------------------
// billboard_quad_expand_core_defines
// Assertion macros used by the billboard quad expansion core.
// ----------------------------------------------------------------------------
`ifndef BILLBOARD_QUAD_EXPAND_CORE_DEFINES_SVH
`define BILLBOARD_QUAD_EXPAND_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BQE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define BQE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/bqe_pkg.sv
// ----------------------------------------------------------------------------
// bqe_pkg
// Types, constants and helper functions of the billboard quad expansion core.
// ----------------------------------------------------------------------------
package bqe_pkg;

   localparam int AXIS_COUNT = 6;
   localparam int COMP_COUNT = 3;
   localparam int CORNER_COUNT = 4;

   // Camera axis register indexes on the csr port
   typedef enum logic [2:0] {
      REG_RIGHT_X = 3'd0,
      REG_RIGHT_Y = 3'd1,
      REG_RIGHT_Z = 3'd2,
      REG_UP_X    = 3'd3,
      REG_UP_Y    = 3'd4,
      REG_UP_Z    = 3'd5
   } reg_index_type;

   localparam logic signed [15:0] AXIS_ONE = 16'sd16384;
   localparam logic signed [15:0] AXIS_ZERO = 16'sd0;

   localparam logic [16:0] FADE_OPAQUE = 17'h10000;
   localparam logic [1:0] CORNER_FIRST = 2'd0;
   localparam logic [1:0] CORNER_LAST = 2'd3;
   localparam int DIV_BITS_PER_STAGE = 4;

   // Restoring divider state: partial remainder and quotient bits so far
   typedef struct packed {
      logic [23:0] rem;
      logic [15:0] quo;
   } div_state_type;

   // Corner order: bottom-left, bottom-right, top-right, top-left
   function automatic logic corner_u(logic [1:0] k);
      return (k == 2'd1) || (k == 2'd2);
   endfunction

   function automatic logic corner_v(logic [1:0] k);
      return k[1];
   endfunction

   // Four quotient bits; the dividend's low bits are zero, so shift in zeros
   function automatic div_state_type div_step(div_state_type s, logic [23:0] d);
      div_state_type r;
      logic [24:0] t;
      r = s;
      for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
         t = {r.rem, 1'b0};
         if (t >= {1'b0, d}) begin
            t = t - {1'b0, d};
            r.quo = {r.quo[14:0], 1'b1};
         end else begin
            r.quo = {r.quo[14:0], 1'b0};
         end
         r.rem = t[23:0];
      end
      return r;
   endfunction

endpackage

>>> design/billboard_quad_expand_core.sv
// ----------------------------------------------------------------------------
// billboard_quad_expand_core
// Expands one particle into four camera-facing billboard vertices with fade.
// ----------------------------------------------------------------------------
//
//   channel  ports                     handshake
//   -------  ------------------------  -----------------------------------
//   req      start, busy, req_*        word taken when start && !busy
//   rsp      rsp_valid, rsp_*          one word per cycle of rsp_valid
//   csr      csr_we, csr_index, _wdata register written when csr_we
//
// A particle passes each stage below in turn before its first vertex; then one
// vertex per cycle. Particle rate is set by the single result port that emits
// four vertices per particle. Stages: capture, axis products, corner offsets,
// vertex adds, emit; the fade divider retires four quotient bits per stage.
// Reset clears the stage valid bits and loads the default camera axes.
// The receiver cannot stall; busy rises only while every later stage is full.
// ----------------------------------------------------------------------------
module billboard_quad_expand_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_centre_x,
   input  logic signed [31:0] req_centre_y,
   input  logic signed [31:0] req_centre_z,
   input  logic        [15:0] req_edge_size,
   input  logic        [23:0] req_life_left,
   input  logic        [23:0] req_life_total,
   input  logic        [15:0] req_layer_in,
   input  logic               csr_we,
   input  logic        [2:0]  csr_index,
   input  logic        [15:0] csr_wdata,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_vertex_x,
   output logic signed [31:0] rsp_vertex_y,
   output logic signed [31:0] rsp_vertex_z,
   output logic               rsp_tex_u,
   output logic               rsp_tex_v,
   output logic        [15:0] rsp_layer_out,
   output logic        [16:0] rsp_fade,
   output logic               rsp_last_corner
);

`include "billboard_quad_expand_core_defines.svh"

   // Camera axes: index 0..2 right, 3..5 up
   logic signed [15:0] axis_ff [bqe_pkg::AXIS_COUNT];

   // Stage valid bits and moves between stages
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic s1_valid_in, s2_valid_in, s3_valid_in, s4_valid_in, s5_valid_in;
   logic s2_free, s3_free, s4_free, s5_free, s5_last;
   logic move12, move23, move34, move45, accept;
   logic [1:0] corner_ff, corner_in;

   // Stage 1: captured word
   logic signed [31:0] s1_centre_ff [bqe_pkg::COMP_COUNT];
   logic [15:0] s1_size_ff;
   logic [23:0] s1_total_ff;
   logic [15:0] s1_layer_ff;
   logic s1_sat_ff;
   bqe_pkg::div_state_type s1_div_ff;

   // Stage 2: axis times edge size
   logic signed [32:0] s2_prod_r_ff [bqe_pkg::COMP_COUNT];
   logic signed [32:0] s2_prod_u_ff [bqe_pkg::COMP_COUNT];
   logic signed [31:0] s2_centre_ff [bqe_pkg::COMP_COUNT];
   logic [23:0] s2_total_ff;
   logic [15:0] s2_layer_ff;
   logic s2_sat_ff;
   bqe_pkg::div_state_type s2_div_ff;

   // Stage 3: rounded corner offsets in Q11.16
   logic signed [26:0] s3_off_ff [bqe_pkg::CORNER_COUNT][bqe_pkg::COMP_COUNT];
   logic signed [26:0] s3_off_in [bqe_pkg::CORNER_COUNT][bqe_pkg::COMP_COUNT];
   logic signed [31:0] s3_centre_ff [bqe_pkg::COMP_COUNT];
   logic [23:0] s3_total_ff;
   logic [15:0] s3_layer_ff;
   logic s3_sat_ff;
   bqe_pkg::div_state_type s3_div_ff;

   // Stage 4: vertex positions
   logic [31:0] s4_vert_ff [bqe_pkg::CORNER_COUNT][bqe_pkg::COMP_COUNT];
   logic [31:0] s4_vert_in [bqe_pkg::CORNER_COUNT][bqe_pkg::COMP_COUNT];
   logic [23:0] s4_total_ff;
   logic [15:0] s4_layer_ff;
   logic s4_sat_ff;
   bqe_pkg::div_state_type s4_div_ff;

   // Stage 5: emit buffer
   logic [31:0] s5_vert_ff [bqe_pkg::CORNER_COUNT][bqe_pkg::COMP_COUNT];
   logic [15:0] s5_layer_ff;
   logic [16:0] s5_fade_ff;
   bqe_pkg::div_state_type s4_div_done;

   // ---------------------------------------------------------------------
   // Camera axis registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff[bqe_pkg::REG_RIGHT_X] <= bqe_pkg::AXIS_ONE;
         axis_ff[bqe_pkg::REG_RIGHT_Y] <= bqe_pkg::AXIS_ZERO;
         axis_ff[bqe_pkg::REG_RIGHT_Z] <= bqe_pkg::AXIS_ZERO;
         axis_ff[bqe_pkg::REG_UP_X]    <= bqe_pkg::AXIS_ZERO;
         axis_ff[bqe_pkg::REG_UP_Y]    <= bqe_pkg::AXIS_ONE;
         axis_ff[bqe_pkg::REG_UP_Z]    <= bqe_pkg::AXIS_ZERO;
      end else if (csr_we) begin
         // drop writes beyond the last register
         case (csr_index)
            bqe_pkg::REG_RIGHT_X: axis_ff[bqe_pkg::REG_RIGHT_X] <= csr_wdata;
            bqe_pkg::REG_RIGHT_Y: axis_ff[bqe_pkg::REG_RIGHT_Y] <= csr_wdata;
            bqe_pkg::REG_RIGHT_Z: axis_ff[bqe_pkg::REG_RIGHT_Z] <= csr_wdata;
            bqe_pkg::REG_UP_X:    axis_ff[bqe_pkg::REG_UP_X]    <= csr_wdata;
            bqe_pkg::REG_UP_Y:    axis_ff[bqe_pkg::REG_UP_Y]    <= csr_wdata;
            bqe_pkg::REG_UP_Z:    axis_ff[bqe_pkg::REG_UP_Z]    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline flow: a stage advances when the next one is empty or leaving.
   // The emit stage leaves after its fourth vertex.
   // ---------------------------------------------------------------------
   always_comb begin
      s5_last = (corner_ff == bqe_pkg::CORNER_LAST);
      s5_free = !s5_valid_ff || s5_last;
      move45  = s4_valid_ff && s5_free;
      s4_free = !s4_valid_ff || move45;
      move34  = s3_valid_ff && s4_free;
      s3_free = !s3_valid_ff || move34;
      move23  = s2_valid_ff && s3_free;
      s2_free = !s2_valid_ff || move23;
      move12  = s1_valid_ff && s2_free;
      busy    = s1_valid_ff && !s2_free;
      accept  = start && !busy;

      s1_valid_in = accept || busy;
      s2_valid_in = move12 || (s2_valid_ff && !move23);
      s3_valid_in = move23 || (s3_valid_ff && !move34);
      s4_valid_in = move34 || (s4_valid_ff && !move45);
      s5_valid_in = move45 || (s5_valid_ff && !s5_last);

      if (move45) begin
         corner_in = bqe_pkg::CORNER_FIRST;
      end else if (s5_valid_ff) begin
         corner_in = corner_ff + 2'd1;
      end else begin
         corner_in = corner_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         corner_ff   <= bqe_pkg::CORNER_FIRST;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
         s5_valid_ff <= s5_valid_in;
         corner_ff   <= corner_in;
      end
   end

   // ---------------------------------------------------------------------
   // Corner offsets: d = +/-r*s +/-u*s in units of 2^-23, round half up to
   // 2^-16 by adding 64 and taking the arithmetic floor of d / 128.
   // ---------------------------------------------------------------------
   always_comb begin
      logic signed [33:0] d;
      logic signed [33:0] pr;
      logic signed [33:0] pu;
      for (int k = 0; k < bqe_pkg::CORNER_COUNT; k++) begin
         for (int c = 0; c < bqe_pkg::COMP_COUNT; c++) begin
            pr = 34'(s2_prod_r_ff[c]);
            pu = 34'(s2_prod_u_ff[c]);
            d = (bqe_pkg::corner_u(2'(k)) ? pr : -pr)
              + (bqe_pkg::corner_v(2'(k)) ? pu : -pu) + 34'sd64;
            s3_off_in[k][c] = d[33:7];
         end
      end
   end

   // Add offsets to the centre, wrapping modulo 2^32
   always_comb begin
      for (int k = 0; k < bqe_pkg::CORNER_COUNT; k++) begin
         for (int c = 0; c < bqe_pkg::COMP_COUNT; c++) begin
            s4_vert_in[k][c] = s3_centre_ff[c]
                             + {{5{s3_off_ff[k][c][26]}}, s3_off_ff[k][c]};
         end
      end
   end

   assign s4_div_done = bqe_pkg::div_step(s4_div_ff, s4_total_ff);

   // ---------------------------------------------------------------------
   // Datapath registers; load on the move into each stage
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_centre_ff[0] <= req_centre_x;
         s1_centre_ff[1] <= req_centre_y;
         s1_centre_ff[2] <= req_centre_z;
         s1_size_ff      <= req_edge_size;
         s1_total_ff     <= req_life_total;
         s1_layer_ff     <= req_layer_in;
         // saturate when left >= total, which covers a zero total
         s1_sat_ff       <= (req_life_left >= req_life_total);
         s1_div_ff.rem   <= (req_life_left >= req_life_total) ? 24'd0 : req_life_left;
         s1_div_ff.quo   <= 16'd0;
      end

      if (move12) begin
         for (int c = 0; c < bqe_pkg::COMP_COUNT; c++) begin
            s2_prod_r_ff[c] <= 33'(axis_ff[c]) * 33'($signed({1'b0, s1_size_ff}));
            s2_prod_u_ff[c] <= 33'(axis_ff[c + bqe_pkg::COMP_COUNT])
                             * 33'($signed({1'b0, s1_size_ff}));
            s2_centre_ff[c] <= s1_centre_ff[c];
         end
         s2_total_ff <= s1_total_ff;
         s2_layer_ff <= s1_layer_ff;
         s2_sat_ff   <= s1_sat_ff;
         s2_div_ff   <= bqe_pkg::div_step(s1_div_ff, s1_total_ff);
      end

      if (move23) begin
         s3_off_ff    <= s3_off_in;
         s3_centre_ff <= s2_centre_ff;
         s3_total_ff  <= s2_total_ff;
         s3_layer_ff  <= s2_layer_ff;
         s3_sat_ff    <= s2_sat_ff;
         s3_div_ff    <= bqe_pkg::div_step(s2_div_ff, s2_total_ff);
      end

      if (move34) begin
         s4_vert_ff  <= s4_vert_in;
         s4_total_ff <= s3_total_ff;
         s4_layer_ff <= s3_layer_ff;
         s4_sat_ff   <= s3_sat_ff;
         s4_div_ff   <= bqe_pkg::div_step(s3_div_ff, s3_total_ff);
      end

      if (move45) begin
         s5_vert_ff  <= s4_vert_ff;
         s5_layer_ff <= s4_layer_ff;
         s5_fade_ff  <= s4_sat_ff ? bqe_pkg::FADE_OPAQUE : {1'b0, s4_div_done.quo};
      end
   end

   // ---------------------------------------------------------------------
   // Result word: one vertex per cycle, selected by the corner count
   // ---------------------------------------------------------------------
   assign rsp_valid       = s5_valid_ff;
   assign rsp_vertex_x    = s5_vert_ff[corner_ff][0];
   assign rsp_vertex_y    = s5_vert_ff[corner_ff][1];
   assign rsp_vertex_z    = s5_vert_ff[corner_ff][2];
   assign rsp_tex_u       = bqe_pkg::corner_u(corner_ff);
   assign rsp_tex_v       = bqe_pkg::corner_v(corner_ff);
   assign rsp_layer_out   = s5_layer_ff;
   assign rsp_fade        = s5_fade_ff;
   assign rsp_last_corner = s5_last;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `BQE_ASSERT_NEXT(a_corner_walk, clock, reset, s5_valid_ff && !s5_last,
      s5_valid_ff && (corner_ff == $past(corner_ff) + 2'd1),
      "emit stage skipped or repeated a corner")
   `BQE_ASSERT_NEXT(a_new_particle_first_corner, clock, reset, move45,
      s5_valid_ff && (corner_ff == bqe_pkg::CORNER_FIRST),
      "new particle did not start at the first corner")
   `BQE_ASSERT_NEXT(a_busy_holds_capture, clock, reset, busy,
      s1_valid_ff && $stable(s1_total_ff) && $stable(s1_size_ff),
      "capture stage changed while stalled")
   `BQE_ASSERT_NOW(a_fade_range, clock, reset, rsp_valid,
      rsp_fade <= bqe_pkg::FADE_OPAQUE,
      "fade above fully opaque")

endmodule
